[hw/rtl/gw_pkg.sv]
// Package for the graph walker: sizes, function and status codes.
// No dependencies.
`timescale 1ns / 1ps
package gw_pkg;
  localparam int MaxVertices = 16;
  localparam int MaxDegree   = 16;
  localparam int VW = $clog2(MaxVertices);
  localparam int DW = $clog2(MaxDegree);
  localparam int CW = VW + 1;
  localparam int AdjDepth = MaxVertices * MaxDegree;
  localparam int AW = VW + DW;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_BFS = 2'd1;
  localparam logic [1:0] FUNC_DFS = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [VW-1:0] vertex;
    logic          last;
    logic [1:0]    status;
  } res_t;
endpackage

[hw/rtl/graph_bfs_dfs_walker.sv]
// Graph walker: add-edge items and BFS/DFS walks, all run by one sequencer fed by the
// single adjacency RAM read port.
// One item is worked at a time; in_stall is high until done.
// Depends on gw_pkg and gw_ram.
`timescale 1ns / 1ps
module graph_bfs_dfs_walker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [4:0]            cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_func,
  input  logic [gw_pkg::VW-1:0] in_node_a,
  input  logic [gw_pkg::VW-1:0] in_node_b,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [gw_pkg::VW-1:0] out_vertex,
  output logic                  out_last,
  output logic [1:0]            out_status
);
  import gw_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_ADD1 = 4'd1, S_ADD2 = 4'd2, S_POP = 4'd3,
    S_RD = 4'd4, S_RDW = 4'd5, S_CHK = 4'd6, S_DFSS = 4'd7, S_DTOP = 4'd8,
    S_DRDW = 4'd9, S_DCHK = 4'd10, S_EMIT = 4'd11, S_FIN = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [4:0] vc_r;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] deg_r [MaxVertices];
  logic [MaxVertices-1:0] vis_r, vis_nxt;
  logic [VW-1:0] q_r [MaxVertices];
  logic [CW-1:0] sidx_r [MaxVertices];
  logic [CW-1:0] head_r, head_nxt, tail_r, tail_nxt, sp_r, sp_nxt;
  logic [CW-1:0] idx_r, idx_nxt, s_r, s_nxt;
  logic [VW-1:0] cur_r, cur_nxt, a_r, b_r;
  logic have_r, have_nxt;           // one vertex is held for emission
  res_t hold_r, hold_nxt;
  res_t out_r;
  logic ov_r, ov_nxt;
  res_t out_nxt;

  // adjacency RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [VW-1:0] wdata, rdata;
  gw_ram #(.Width(VW), .Depth(AdjDepth)) u_adj (
    .clk, .we, .waddr, .wdata, .raddr, .rdata);

  always_comb begin
    if (vc_r == 5'd0) n_eff = CW'(1);
    else if ({1'b0, vc_r} > 6'(MaxVertices)) n_eff = CW'(MaxVertices);
    else n_eff = CW'(vc_r);
  end

  logic in_acc, out_free, push_q, push_s, pop_s, ld_sidx;
  logic [VW-1:0] push_v;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !ov_r || !out_stall;

  logic [CW-1:0] dega, degb;
  assign dega = deg_r[a_r];
  assign degb = deg_r[b_r];
  logic [VW-1:0] top_v;
  assign top_v = q_r[VW'(sp_r - CW'(1))];

  always_comb begin
    state_nxt = state_r;
    vis_nxt = vis_r; head_nxt = head_r; tail_nxt = tail_r; sp_nxt = sp_r;
    idx_nxt = idx_r; s_nxt = s_r; cur_nxt = cur_r;
    have_nxt = have_r; hold_nxt = hold_r;
    ov_nxt = ov_r && out_stall; out_nxt = out_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = {cur_r, idx_r[DW-1:0]};
    push_q = 1'b0; push_s = 1'b0; pop_s = 1'b0; ld_sidx = 1'b0; push_v = '0;
    unique case (state_r)
      S_IDLE: if (in_acc) begin
        unique case (in_func)
          FUNC_ADD: state_nxt = S_ADD1;
          FUNC_BFS: begin
            vis_nxt = '0;
            if ({1'b0, in_node_a} >= n_eff) begin
              hold_nxt = '{vertex: '0, last: 1'b1, status: ST_RANGE};
              have_nxt = 1'b1; state_nxt = S_FIN;
            end else begin
              vis_nxt[in_node_a] = 1'b1; push_q = 1'b1; push_v = in_node_a;
              head_nxt = '0; tail_nxt = CW'(1); state_nxt = S_POP;
            end
          end
          FUNC_DFS: begin
            vis_nxt = '0; s_nxt = '0; state_nxt = S_DFSS;
          end
          default: ;
        endcase
      end
      S_ADD1: begin
        priority if ({1'b0, a_r} >= n_eff || {1'b0, b_r} >= n_eff) begin
          hold_nxt = '{vertex: '0, last: 1'b1, status: ST_RANGE};
          have_nxt = 1'b1; state_nxt = S_FIN;
        end else if ((a_r == b_r && dega + CW'(2) > CW'(MaxDegree)) ||
                     dega >= CW'(MaxDegree) || degb >= CW'(MaxDegree)) begin
          hold_nxt = '{vertex: '0, last: 1'b1, status: ST_FULL};
          have_nxt = 1'b1; state_nxt = S_FIN;
        end else begin
          we = 1'b1; waddr = {a_r, dega[DW-1:0]}; wdata = b_r; state_nxt = S_ADD2;
        end
      end
      S_ADD2: begin
        we = 1'b1; waddr = {b_r, degb[DW-1:0]}; wdata = a_r;
        hold_nxt = '{vertex: '0, last: 1'b1, status: ST_OK};
        have_nxt = 1'b1; state_nxt = S_FIN;
      end
      // BFS: dequeue, emit (previous held vertex first)
      S_POP: begin
        if (head_r == tail_r) state_nxt = S_FIN;
        else if (!have_r || out_free) begin
          if (have_r) begin ov_nxt = 1'b1; out_nxt = hold_r; end
          cur_nxt = q_r[head_r[VW-1:0]]; head_nxt = head_r + CW'(1);
          hold_nxt = '{vertex: q_r[head_r[VW-1:0]], last: 1'b0, status: ST_OK};
          have_nxt = 1'b1; idx_nxt = '0; state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (idx_r >= deg_r[cur_r] || idx_r >= CW'(MaxDegree)) state_nxt = S_POP;
        else state_nxt = S_RDW;
      end
      S_RDW: state_nxt = S_CHK;
      S_CHK: begin
        if ({1'b0, rdata} < n_eff && !vis_r[rdata] && tail_r < CW'(MaxVertices)) begin
          vis_nxt[rdata] = 1'b1; push_q = 1'b1; push_v = rdata;
          tail_nxt = tail_r + CW'(1);
        end
        idx_nxt = idx_r + CW'(1); state_nxt = S_RD;
      end
      // DFS: next unvisited start vertex
      S_DFSS: begin
        if (s_r >= n_eff) state_nxt = S_FIN;
        else if (vis_r[s_r[VW-1:0]]) s_nxt = s_r + CW'(1);
        else begin
          push_v = s_r[VW-1:0]; state_nxt = S_EMIT;
        end
      end
      // emit the vertex in cur_r: mark it visited, push it, hold it for output
      S_EMIT: if (!have_r || out_free) begin
        if (have_r) begin ov_nxt = 1'b1; out_nxt = hold_r; end
        hold_nxt = '{vertex: cur_r, last: 1'b0, status: ST_OK};
        have_nxt = 1'b1; vis_nxt[cur_r] = 1'b1; push_s = 1'b1;
        sp_nxt = sp_r + CW'(1); state_nxt = S_DTOP;
      end
      S_DTOP: begin
        if (sp_r == '0) begin s_nxt = s_r + CW'(1); state_nxt = S_DFSS; end
        else begin
          cur_nxt = top_v; idx_nxt = sidx_r[VW'(sp_r - CW'(1))];
          if (sidx_r[VW'(sp_r - CW'(1))] < deg_r[top_v] &&
              sidx_r[VW'(sp_r - CW'(1))] < CW'(MaxDegree)) state_nxt = S_DRDW;
          else begin pop_s = 1'b1; sp_nxt = sp_r - CW'(1); end
        end
      end
      S_DRDW: begin ld_sidx = 1'b1; state_nxt = S_DCHK; end
      S_DCHK: begin
        if ({1'b0, rdata} < n_eff && !vis_r[rdata] && sp_r < CW'(MaxVertices)) begin
          cur_nxt = rdata; state_nxt = S_EMIT;
        end else state_nxt = S_DTOP;
      end
      S_FIN: if (out_free) begin
        if (have_r) begin
          ov_nxt = 1'b1; out_nxt = hold_r; out_nxt.last = 1'b1;
        end
        have_nxt = 1'b0; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_DFSS && state_nxt == S_EMIT) begin
      cur_nxt = s_r[VW-1:0]; sp_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; vc_r <= 5'd16; vis_r <= '0;
      have_r <= 1'b0; ov_r <= 1'b0; sp_r <= '0; head_r <= '0; tail_r <= '0;
      for (int i = 0; i < MaxVertices; i++) deg_r[i] <= '0;
    end else begin
      state_r <= state_nxt; vis_r <= vis_nxt;
      have_r <= have_nxt; ov_r <= ov_nxt; sp_r <= sp_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt;
      if (cfg_we) vc_r <= cfg_wdata;
      if (state_r == S_ADD1 && state_nxt == S_ADD2) deg_r[a_r] <= dega + CW'(1);
      if (state_r == S_ADD2) deg_r[b_r] <= degb + CW'(1);
    end
  end

  // payload registers; a queue push lands at the slot just below the new tail
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; s_r <= s_nxt; cur_r <= cur_nxt;
    hold_r <= hold_nxt; out_r <= out_nxt;
    if (in_acc) begin a_r <= in_node_a; b_r <= in_node_b; end
    if (push_q) q_r[VW'(tail_nxt - CW'(1))] <= push_v;
    if (push_s) begin q_r[sp_r[VW-1:0]] <= cur_r; sidx_r[sp_r[VW-1:0]] <= '0; end
    if (ld_sidx) sidx_r[VW'(sp_r - CW'(1))] <= idx_r + CW'(1);
  end

  assign out_valid  = ov_r;
  assign out_vertex = out_r.vertex;
  assign out_last   = out_r.last;
  assign out_status = out_r.status;

`ifndef ASSERT_OFF
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accepting while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(out_r))) else $error("result lost");
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CW'(MaxVertices)) else $error("stack overflow");
`endif
endmodule

[hw/rtl/gw_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module gw_ram #(
  parameter int Width = 4,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[verif/graph_bfs_dfs_walker_tb.sv]
// Testbench for graph_bfs_dfs_walker: directed and random edge/walk items, checked
// against an in-bench graph predictor. Depends on gw_pkg and the walker RTL.
`timescale 1ns / 1ps
module graph_bfs_dfs_walker_tb;
  import gw_pkg::*;

  localparam int CYCLE_LIMIT = 8000000;
  localparam int DRAIN_CYCLES = 1200;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  logic [4:0]    cfg_wdata = '0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [1:0]    in_func = FUNC_ADD;
  logic [VW-1:0] in_node_a = '0;
  logic [VW-1:0] in_node_b = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [VW-1:0] out_vertex;
  logic          out_last;
  logic [1:0]    out_status;

  // graph mirror
  logic [VW-1:0] adj_list [MaxVertices][MaxDegree];
  int            degree [MaxVertices];
  logic [4:0]    vcount_reg;
  res_t          pending_results [$];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  bit  hold_start = 0;

  graph_bfs_dfs_walker DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_node_a(in_node_a), .in_node_b(in_node_b),
    .out_valid(out_valid), .out_stall(out_stall), .out_vertex(out_vertex),
    .out_last(out_last), .out_status(out_status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int eff_count();
    if (vcount_reg == 0) return 1;
    if (vcount_reg > MaxVertices) return MaxVertices;
    return int'(vcount_reg);
  endfunction

  function automatic res_t mk_res(int v, bit lst, logic [1:0] st);
    res_t r;
    r.vertex = v[VW-1:0];
    r.last = lst;
    r.status = st;
    return r;
  endfunction

  // append one expected result at the tail of the scoreboard queue
  task automatic expect_res(res_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  // work out the results one accepted item causes
  task automatic model_item(logic [1:0] func, int a, int b);
    int n;
    bit seen [MaxVertices];
    int q [MaxVertices];
    int nxt [MaxVertices];
    int head, tail, sp, p, w, v, s, k;
    res_t walk [$];
    n = eff_count();
    case (func)
      FUNC_ADD: begin
        if (a >= n || b >= n) expect_res(mk_res(0, 1, ST_RANGE));
        else if ((a == b && degree[a] + 2 > MaxDegree) ||
                 (a != b && (degree[a] >= MaxDegree || degree[b] >= MaxDegree)))
          expect_res(mk_res(0, 1, ST_FULL));
        else begin
          adj_list[a][degree[a]] = b[VW-1:0];
          degree[a]++;
          adj_list[b][degree[b]] = a[VW-1:0];
          degree[b]++;
          expect_res(mk_res(0, 1, ST_OK));
        end
      end
      FUNC_BFS: begin
        if (a >= n) expect_res(mk_res(0, 1, ST_RANGE));
        else begin
          foreach (seen[i]) seen[i] = 0;
          head = 0; tail = 0;
          seen[a] = 1; q[tail++] = a;
          while (head < tail) begin
            p = q[head++];
            walk.insert(walk.size(), mk_res(p, 0, ST_OK));
            for (k = 0; k < degree[p]; k++) begin
              w = adj_list[p][k];
              if (w < n && !seen[w] && tail < MaxVertices) begin
                seen[w] = 1; q[tail++] = w;
              end
            end
          end
        end
      end
      FUNC_DFS: begin
        foreach (seen[i]) seen[i] = 0;
        for (s = 0; s < n; s++) begin
          if (!seen[s]) begin
            seen[s] = 1;
            walk.insert(walk.size(), mk_res(s, 0, ST_OK));
            q[0] = s; nxt[0] = 0; sp = 1;
            while (sp > 0) begin
              v = q[sp-1];
              if (nxt[sp-1] < degree[v]) begin
                w = adj_list[v][nxt[sp-1]];
                nxt[sp-1]++;
                if (w < n && !seen[w] && sp < MaxVertices) begin
                  seen[w] = 1;
                  walk.insert(walk.size(), mk_res(w, 0, ST_OK));
                  q[sp] = w; nxt[sp] = 0; sp++;
                end
              end else sp--;
            end
          end
        end
      end
      default: ;
    endcase
    if (walk.size() > 0) begin
      walk[walk.size()-1].last = 1'b1;
      foreach (walk[i]) expect_res(walk[i]);
    end
  endtask

  // offer one item, hold it until accepted
  task automatic send_item(logic [1:0] func, int a, int b);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= func;
    in_node_a <= a[VW-1:0];
    in_node_b <= b[VW-1:0];
    do @(posedge clk); while (in_stall);
    model_item(func, a, b);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // register writes only with the block idle
  task automatic write_count(logic [4:0] value);
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    vcount_reg = value;
  endtask

  // receiver: random stall, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_start = 0;
        repeat (400) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result vertex=%0d last=%0d status=%0d",
               out_vertex, out_last, out_status);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_vertex !== exp_r.vertex) begin
          $error("vertex exp=%0d got=%0d", exp_r.vertex, out_vertex); fail_count++;
        end
        if (out_last !== exp_r.last) begin
          $error("last exp=%0d got=%0d", exp_r.last, out_last); fail_count++;
        end
        if (out_status !== exp_r.status) begin
          $error("status exp=%0d got=%0d", exp_r.status, out_status); fail_count++;
        end
      end
    end
  end

  // edge extremes, self-loops, range errors, stale neighbors, odd counts
  task automatic test_directed();
    send_item(FUNC_ADD, 0, 15);
    send_item(FUNC_ADD, 15, 0);
    send_item(FUNC_ADD, 5, 5);
    send_item(FUNC_ADD, 0, 1);
    send_item(FUNC_BFS, 0, 9);
    send_item(FUNC_BFS, 15, 0);
    send_item(FUNC_DFS, 3, 3);
    send_item(FUNC_NONE, 2, 2);
    write_count(5'd4);
    send_item(FUNC_ADD, 3, 4);
    send_item(FUNC_ADD, 4, 0);
    send_item(FUNC_ADD, 1, 3);
    send_item(FUNC_BFS, 7, 0);
    send_item(FUNC_BFS, 0, 0);
    send_item(FUNC_DFS, 0, 0);
    write_count(5'd0);
    send_item(FUNC_DFS, 0, 0);
    send_item(FUNC_BFS, 0, 0);
    send_item(FUNC_BFS, 1, 0);
    send_item(FUNC_ADD, 0, 0);
    write_count(5'd31);
    send_item(FUNC_DFS, 0, 0);
    send_item(FUNC_BFS, 5, 0);
  endtask

  // mostly in-range edges, some walks, a little noise
  task automatic test_random(int count);
    int r, n;
    repeat (count) begin
      r = $urandom_range(99);
      n = eff_count();
      if (r < 60) begin
        if ($urandom_range(9) == 0)
          send_item(FUNC_ADD, $urandom_range(15), $urandom_range(15));
        else
          send_item(FUNC_ADD, $urandom_range(n-1), $urandom_range(n-1));
      end else if (r < 78) send_item(FUNC_BFS, $urandom_range(15), $urandom_range(15));
      else if (r < 96) send_item(FUNC_DFS, $urandom_range(15), $urandom_range(15));
      else send_item(FUNC_NONE, $urandom_range(15), $urandom_range(15));
    end
  endtask

  // long receiver hold-off with the sender still offering items
  task automatic test_backpressure();
    hold_start = 1;
    test_random(12);
    wait_results_done();
  endtask

  initial begin
    vcount_reg = 5'd16;
    foreach (degree[i]) degree[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 11; rcv_idle_pct = 65;
    test_directed();
    write_count(5'd16);
    test_random(140);
    test_backpressure();
    write_count(5'd9);
    snd_idle_pct = 65; rcv_idle_pct = 11;
    test_random(60);
    write_count(5'd1);
    test_random(20);
    write_count(5'd16);
    test_random(60);
    snd_idle_pct = 0; rcv_idle_pct = 0;
    write_count(5'($urandom_range(31)));
    test_random(70);
    write_count(5'd16);
    test_random(70);

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

[sim.f]
hw/rtl/gw_pkg.sv
hw/rtl/gw_ram.sv
hw/rtl/graph_bfs_dfs_walker.sv
verif/graph_bfs_dfs_walker_tb.sv
